[hw/rtl/sll_pkg.sv]
// ----------------------------------------------------------------------------
// Shell line lexer package
// Types, codes and helper functions shared by the lexer core and top level.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned LimitW = 2;

  localparam logic [LimitW-1:0] RunLimitReset = 2'd2;

  localparam logic [CharW-1:0] ChLess   = 8'h3C;  // '<'
  localparam logic [CharW-1:0] ChGreat  = 8'h3E;  // '>'
  localparam logic [CharW-1:0] ChPipe   = 8'h7C;  // '|'
  localparam logic [CharW-1:0] ChDquote = 8'h22;
  localparam logic [CharW-1:0] ChSquote = 8'h27;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_OPER = 2'd2
  } lex_mode_e;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_LESS  = 2'd1,
    OP_GREAT = 2'd2,
    OP_PIPE  = 2'd3
  } oper_e;

  typedef enum logic [1:0] {
    ROLE_SEP  = 2'd0,
    ROLE_WORD = 2'd1,
    ROLE_OPER = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_DQUOTE = 2'd1,
    ERR_SQUOTE = 2'd2,
    ERR_RUN    = 2'd3
  } err_e;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             line_end;
  } in_word_t;

  typedef struct packed {
    logic [CharW-1:0] char_out;
    logic [1:0]       role;
    logic             token_start;
    logic [1:0]       error_code;
    logic             line_done;
  } out_word_t;

  function automatic oper_e oper_code(logic [CharW-1:0] c);
    oper_e code;
    code = OP_NONE;
    if (c == ChLess) begin
      code = OP_LESS;
    end else if (c == ChGreat) begin
      code = OP_GREAT;
    end else if (c == ChPipe) begin
      code = OP_PIPE;
    end
    return code;
  endfunction

  function automatic logic is_blank(logic [CharW-1:0] c);
    return (c inside {[ChTab:ChCr], ChSpace});
  endfunction

endpackage

[hw/rtl/sll_lex_core.sv]
// ----------------------------------------------------------------------------
// Shell line lexer core
// Holds the per-line lexer state and the run limit, and classifies one byte.
// ----------------------------------------------------------------------------
module sll_lex_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sll_pkg::LimitW-1:0]    cfg_data_i,
  input  logic                          step_i,
  input  sll_pkg::in_word_t             item_i,
  output sll_pkg::out_word_t            result_o
);

  sll_pkg::lex_mode_e            mode_q, mode_d;
  sll_pkg::quote_e               quote_q, quote_d;
  sll_pkg::oper_e                run_char_q, run_char_d;
  logic [1:0]                    run_len_q, run_len_d;
  sll_pkg::err_e                 err_q, err_d;
  logic [sll_pkg::LimitW-1:0]    limit_q;

  sll_pkg::oper_e                op;
  sll_pkg::role_e                role;
  logic                          start;
  logic [2:0]                    run_next;
  logic                          run_err;

  always_comb begin
    mode_d     = mode_q;
    quote_d    = quote_q;
    run_char_d = run_char_q;
    run_len_d  = run_len_q;
    err_d      = err_q;
    role       = sll_pkg::ROLE_SEP;
    start      = 1'b0;
    run_next   = 3'd0;
    run_err    = 1'b0;
    op         = sll_pkg::oper_code(item_i.char_in);

    if (mode_q == sll_pkg::MODE_WORD && quote_q != sll_pkg::QUOTE_NONE) begin
      // Everything inside quotes belongs to the word, blanks and operators too.
      role = sll_pkg::ROLE_WORD;
      if ((quote_q == sll_pkg::QUOTE_DOUBLE && item_i.char_in == sll_pkg::ChDquote) ||
          (quote_q == sll_pkg::QUOTE_SINGLE && item_i.char_in == sll_pkg::ChSquote)) begin
        quote_d = sll_pkg::QUOTE_NONE;
      end
    end else if (sll_pkg::is_blank(item_i.char_in)) begin
      mode_d     = sll_pkg::MODE_IDLE;
      run_char_d = sll_pkg::OP_NONE;
      run_len_d  = 2'd0;
    end else if (op != sll_pkg::OP_NONE) begin
      role = sll_pkg::ROLE_OPER;
      if (mode_q == sll_pkg::MODE_OPER && run_char_q == op) begin
        run_next = {1'b0, run_len_q} + 3'd1;
      end else begin
        start      = 1'b1;
        mode_d     = sll_pkg::MODE_OPER;
        run_char_d = op;
        run_next   = 3'd1;
      end
      // The stored length saturates at three, so a fourth byte still reads as too long.
      run_err   = (run_next > {1'b0, limit_q});
      run_len_d = run_next[2] ? 2'd3 : run_next[1:0];
    end else begin
      role = sll_pkg::ROLE_WORD;
      if (mode_q != sll_pkg::MODE_WORD) begin
        start      = 1'b1;
        mode_d     = sll_pkg::MODE_WORD;
        run_char_d = sll_pkg::OP_NONE;
        run_len_d  = 2'd0;
      end
      if (item_i.char_in == sll_pkg::ChDquote) begin
        quote_d = sll_pkg::QUOTE_DOUBLE;
      end else if (item_i.char_in == sll_pkg::ChSquote) begin
        quote_d = sll_pkg::QUOTE_SINGLE;
      end
    end

    // The first error of the line is kept.
    if (run_err && err_d == sll_pkg::ERR_NONE) begin
      err_d = sll_pkg::ERR_RUN;
    end
    if (item_i.line_end && quote_d != sll_pkg::QUOTE_NONE && err_d == sll_pkg::ERR_NONE) begin
      err_d = (quote_d == sll_pkg::QUOTE_DOUBLE) ? sll_pkg::ERR_DQUOTE : sll_pkg::ERR_SQUOTE;
    end

    result_o.char_out    = item_i.char_in;
    result_o.role        = role;
    result_o.token_start = start;
    result_o.error_code  = err_d;
    result_o.line_done   = item_i.line_end;

    if (item_i.line_end) begin
      mode_d     = sll_pkg::MODE_IDLE;
      quote_d    = sll_pkg::QUOTE_NONE;
      run_char_d = sll_pkg::OP_NONE;
      run_len_d  = 2'd0;
      err_d      = sll_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= sll_pkg::MODE_IDLE;
      quote_q    <= sll_pkg::QUOTE_NONE;
      run_char_q <= sll_pkg::OP_NONE;
      run_len_q  <= 2'd0;
      err_q      <= sll_pkg::ERR_NONE;
    end else if (step_i) begin
      mode_q     <= mode_d;
      quote_q    <= quote_d;
      run_char_q <= run_char_d;
      run_len_q  <= run_len_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= sll_pkg::RunLimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  // A finished line leaves the lexer in its reset state.
  a_line_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.line_end |=> mode_q == sll_pkg::MODE_IDLE &&
      quote_q == sll_pkg::QUOTE_NONE && err_q == sll_pkg::ERR_NONE)
    else $error("lexer state not cleared after line end");

  // A recorded error is never replaced within the line.
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.line_end && err_q != sll_pkg::ERR_NONE |=> err_q == $past(err_q))
    else $error("sticky error changed within a line");

  // A quote can only be open while inside a word.
  a_quote_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quote_q != sll_pkg::QUOTE_NONE |-> mode_q == sll_pkg::MODE_WORD)
    else $error("quote open outside a word");

  // An operator run has a run character and a nonzero length.
  a_run_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == sll_pkg::MODE_OPER |-> run_char_q != sll_pkg::OP_NONE && run_len_q != 2'd0)
    else $error("operator run state inconsistent");
`endif

endmodule

[hw/rtl/shell_line_lexer_unit.sv]
// ----------------------------------------------------------------------------
// Shell line lexer unit
// Byte-serial lexer for a shell command line with one result word per byte.
// ----------------------------------------------------------------------------
// Usage: feed the command line one byte per word on the input channel
// (in_valid_i/in_ready_o/in_data_i), with line_end set on its last byte.
// Each byte yields exactly one result word on the output channel
// (out_valid_o/out_ready_i/out_data_o): the byte, its role, a token start
// flag, the sticky error of the line and the line-done flag.
// The run limit is written through cfg_valid_i/cfg_data_i; cfg_ready_o is
// always high. Write it only while no bytes are in flight.
// The result passes one input register, then the classify logic into the
// result register. Throughput is one byte per cycle while the receiver does
// not stall, as the lexer state updates once for every byte taken.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready_o drops only once both are occupied.
// Reset empties both registers, clears the lexer state and sets the run
// limit to two.
// ----------------------------------------------------------------------------
module shell_line_lexer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sll_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sll_pkg::out_word_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sll_pkg::LimitW-1:0]    cfg_data_i
);

  logic                 in_valid_q;
  sll_pkg::in_word_t    in_data_q;
  logic                 out_valid_q;
  sll_pkg::out_word_t   out_data_q;
  sll_pkg::out_word_t   result;
  logic                 out_free;
  logic                 advance;

  assign out_free    = !out_valid_q || out_ready_i;
  assign advance     = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || out_free;
  assign cfg_ready_o = 1'b1;

  sll_lex_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .item_i     (in_data_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[verif/shell_line_lexer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell line lexer unit testbench
// Feeds command lines byte by byte through the valid/ready input channel,
// predicts the role, token start and sticky error of every byte with its own
// lexer model, and checks each result word in order. The run covers all run
// limit settings, random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module shell_line_lexer_unit_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned MaxReports = 10;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  sll_pkg::in_word_t   in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  sll_pkg::out_word_t  out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_data_i  = '0;

  shell_line_lexer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Lexer state as predicted by the testbench.
  sll_pkg::lex_mode_e  mode_q      = sll_pkg::MODE_IDLE;
  sll_pkg::quote_e     quote_q     = sll_pkg::QUOTE_NONE;
  sll_pkg::oper_e      run_op_q    = sll_pkg::OP_NONE;
  logic [1:0]          run_len_q   = '0;
  sll_pkg::err_e       line_err_q  = sll_pkg::ERR_NONE;
  logic [1:0]          run_limit_q = sll_pkg::RunLimitReset;

  sll_pkg::in_word_t   pending_bytes[$];
  sll_pkg::out_word_t  expected_results[$];

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned holds_asked        = 0;
  int unsigned holds_served;
  int unsigned hold_left;
  int unsigned mismatch_count     = 0;
  int unsigned cycle_count        = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Classifies one byte and advances the predicted lexer state.
  function automatic sll_pkg::out_word_t lex_predict(sll_pkg::in_word_t w);
    logic [7:0]         c;
    sll_pkg::oper_e     op;
    logic [2:0]         next_len;
    sll_pkg::role_e     role;
    logic               start;
    sll_pkg::out_word_t r;
    c     = w.char_in;
    role  = sll_pkg::ROLE_SEP;
    start = 1'b0;
    case (c)
      sll_pkg::ChLess:  op = sll_pkg::OP_LESS;
      sll_pkg::ChGreat: op = sll_pkg::OP_GREAT;
      sll_pkg::ChPipe:  op = sll_pkg::OP_PIPE;
      default:          op = sll_pkg::OP_NONE;
    endcase
    if (mode_q == sll_pkg::MODE_WORD && quote_q != sll_pkg::QUOTE_NONE) begin
      role = sll_pkg::ROLE_WORD;
      if ((quote_q == sll_pkg::QUOTE_DOUBLE && c == sll_pkg::ChDquote) ||
          (quote_q == sll_pkg::QUOTE_SINGLE && c == sll_pkg::ChSquote)) begin
        quote_q = sll_pkg::QUOTE_NONE;
      end
    end else if (c == sll_pkg::ChSpace || (c >= sll_pkg::ChTab && c <= sll_pkg::ChCr)) begin
      mode_q    = sll_pkg::MODE_IDLE;
      run_op_q  = sll_pkg::OP_NONE;
      run_len_q = '0;
    end else if (op != sll_pkg::OP_NONE) begin
      role = sll_pkg::ROLE_OPER;
      if (mode_q == sll_pkg::MODE_OPER && run_op_q == op) begin
        next_len = {1'b0, run_len_q} + 3'd1;
      end else begin
        start    = 1'b1;
        mode_q   = sll_pkg::MODE_OPER;
        run_op_q = op;
        next_len = 3'd1;
      end
      if (next_len > {1'b0, run_limit_q} && line_err_q == sll_pkg::ERR_NONE) begin
        line_err_q = sll_pkg::ERR_RUN;
      end
      run_len_q = (next_len > 3'd3) ? 2'd3 : next_len[1:0];
    end else begin
      role = sll_pkg::ROLE_WORD;
      if (mode_q != sll_pkg::MODE_WORD) begin
        start     = 1'b1;
        mode_q    = sll_pkg::MODE_WORD;
        run_op_q  = sll_pkg::OP_NONE;
        run_len_q = '0;
      end
      if (c == sll_pkg::ChDquote) begin
        quote_q = sll_pkg::QUOTE_DOUBLE;
      end else if (c == sll_pkg::ChSquote) begin
        quote_q = sll_pkg::QUOTE_SINGLE;
      end
    end
    if (w.line_end && quote_q != sll_pkg::QUOTE_NONE &&
        line_err_q == sll_pkg::ERR_NONE) begin
      line_err_q = (quote_q == sll_pkg::QUOTE_DOUBLE) ? sll_pkg::ERR_DQUOTE
                                                      : sll_pkg::ERR_SQUOTE;
    end
    r.char_out    = c;
    r.role        = role;
    r.token_start = start;
    r.error_code  = line_err_q;
    r.line_done   = w.line_end;
    if (w.line_end) begin
      mode_q     = sll_pkg::MODE_IDLE;
      quote_q    = sll_pkg::QUOTE_NONE;
      run_op_q   = sll_pkg::OP_NONE;
      run_len_q  = '0;
      line_err_q = sll_pkg::ERR_NONE;
    end
    return r;
  endfunction

  // Input driver: the expectation is formed at the edge that accepts the word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(lex_predict(in_data_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output ready, with an occasional long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left    <= LongHold;
      out_ready_i  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    sll_pkg::out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("unexpected result word: byte %02h role %0d start %0d err %0d done %0d",
                   out_data_o.char_out, out_data_o.role, out_data_o.token_start,
                   out_data_o.error_code, out_data_o.line_done);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.char_out !== want.char_out || out_data_o.role !== want.role ||
            out_data_o.token_start !== want.token_start ||
            out_data_o.error_code !== want.error_code ||
            out_data_o.line_done !== want.line_done) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("mismatch: got byte %02h role %0d start %0d err %0d done %0d",
                     out_data_o.char_out, out_data_o.role, out_data_o.token_start,
                     out_data_o.error_code, out_data_o.line_done);
            $display("     expected byte %02h role %0d start %0d err %0d done %0d",
                     want.char_out, want.role, want.token_start,
                     want.error_code, want.line_done);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("shell_line_lexer_unit_tb: errors");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] c, input logic last);
    sll_pkg::in_word_t w;
    w.char_in  = c;
    w.line_end = last;
    pending_bytes.push_back(w);
  endtask

  // Builds one random command line. Most lines are made of plausible tokens;
  // unclosed quotes, long operator runs and stray bytes break some of them.
  task automatic add_random_line();
    logic [7:0] line_buf[$];
    logic [7:0] qc;
    logic [7:0] oc;
    int         tokens;
    int         pick;
    int         len;
    tokens = $urandom_range(1, 6);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        len = $urandom_range(1, 2);
        for (int i = 0; i < len; i++) begin
          line_buf.push_back(($urandom_range(3) == 0) ? sll_pkg::ChSpace
                                                      : 8'($urandom_range(9, 13)));
        end
      end else if (pick < 55) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          line_buf.push_back(8'h61 + 8'($urandom_range(25)));
        end
      end else if (pick < 80) begin
        case ($urandom_range(2))
          0:       oc = sll_pkg::ChLess;
          1:       oc = sll_pkg::ChGreat;
          default: oc = sll_pkg::ChPipe;
        endcase
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          line_buf.push_back(oc);
        end
      end else if (pick < 92) begin
        qc = $urandom_range(1) ? sll_pkg::ChDquote : sll_pkg::ChSquote;
        if ($urandom_range(1)) begin
          line_buf.push_back(8'h61 + 8'($urandom_range(25)));
        end
        line_buf.push_back(qc);
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(3))
            0:       line_buf.push_back(sll_pkg::ChSpace);
            1:       line_buf.push_back(sll_pkg::ChPipe);
            default: line_buf.push_back(8'($urandom_range(255)));
          endcase
        end
        if ($urandom_range(4) != 0) begin
          line_buf.push_back(qc);
        end
      end else begin
        line_buf.push_back(8'($urandom_range(255)));
      end
    end
    foreach (line_buf[i]) begin
      add_byte(line_buf[i], i == line_buf.size() - 1);
    end
  endtask

  task automatic add_random_bytes(input int unsigned count);
    int unsigned target;
    target = pending_bytes.size() + count;
    while (pending_bytes.size() < target) begin
      add_random_line();
    end
  endtask

  // Waits until every word has been sent and every result has come back.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_run_limit(input logic [1:0] limit);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    run_limit_q = limit;
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines at the reset limit of two.
    // Zero byte in a word, CR as separator, a run of three, then stray bytes.
    add_byte("a", 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(sll_pkg::ChCr, 1'b0);
    add_byte(sll_pkg::ChGreat, 1'b0);
    add_byte(sll_pkg::ChGreat, 1'b0);
    add_byte(sll_pkg::ChGreat, 1'b0);
    add_byte(sll_pkg::ChPipe, 1'b0);
    add_byte("x", 1'b0);
    add_byte(8'hFF, 1'b1);
    // Quote opened inside a word hides a space, a pipe and a tab; a single quote
    // opened on the last byte is left unclosed.
    add_byte("w", 1'b0);
    add_byte(sll_pkg::ChDquote, 1'b0);
    add_byte(sll_pkg::ChSpace, 1'b0);
    add_byte(sll_pkg::ChPipe, 1'b0);
    add_byte(sll_pkg::ChTab, 1'b0);
    add_byte(sll_pkg::ChDquote, 1'b0);
    add_byte(sll_pkg::ChSquote, 1'b1);
    // Unclosed double quote after a non-blank control byte.
    add_byte(8'h08, 1'b0);
    add_byte(sll_pkg::ChDquote, 1'b0);
    add_byte("a", 1'b1);
    // The run error comes first and must survive the later open quote.
    add_byte(sll_pkg::ChLess, 1'b0);
    add_byte(sll_pkg::ChLess, 1'b0);
    add_byte(sll_pkg::ChLess, 1'b0);
    add_byte(8'h0A, 1'b0);
    add_byte(sll_pkg::ChDquote, 1'b0);
    add_byte(8'h0E, 1'b1);
    wait_drained();

    // No idling; the long output stall fills the block at the start.
    write_run_limit(2'd3);
    holds_asked++;
    add_random_bytes(100);
    wait_drained();

    sender_idle_pct = 69;
    write_run_limit(2'd1);
    add_random_bytes(90);
    wait_drained();

    sender_idle_pct    = 0;
    receiver_stall_pct = 69;
    write_run_limit(2'd0);
    add_random_bytes(90);
    wait_drained();

    sender_idle_pct    = 30;
    receiver_stall_pct = 30;
    for (int k = 0; k < 4; k++) begin
      write_run_limit(2'($urandom_range(3)));
      add_random_bytes(36);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("shell_line_lexer_unit_tb: clean");
    end else begin
      $display("shell_line_lexer_unit_tb: errors");
    end
    $finish;
  end

endmodule
